// File: hdl/ipv4dp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ipv4dp_pkg;

  localparam int CharW = 8;
  localparam int AddrW = 32;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [AddrW-1:0] LIMIT_24 = 32'h00ff_ffff;
  localparam logic [AddrW-1:0] LIMIT_16 = 32'h0000_ffff;
  localparam logic [AddrW-1:0] LIMIT_8  = 32'h0000_00ff;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0d;
  localparam logic [CharW-1:0] CH_X_LO  = 8'h78;
  localparam logic [CharW-1:0] CH_X_UP  = 8'h58;
  localparam logic [CharW-1:0] CH_A_LO  = 8'h61;
  localparam logic [CharW-1:0] CH_F_LO  = 8'h66;
  localparam logic [CharW-1:0] CH_A_UP  = 8'h41;
  localparam logic [CharW-1:0] CH_F_UP  = 8'h46;

  typedef struct packed {
    logic [1:0]            phase;
    logic [1:0]            base;
    logic [AddrW-1:0]      part;
    logic [1:0]            seen;
    logic [2:0][AddrW-1:0] earlier;
  } ipv4dp_state_t;

  typedef struct packed {
    logic             emit;
    logic [AddrW-1:0] address;
    logic             ok;
  } ipv4dp_result_t;

endpackage
`default_nettype wire

// File: hdl/ipv4dp_step.sv
`timescale 1ns / 1ps
`default_nettype none
module ipv4dp_step (
  input  wire logic [ipv4dp_pkg::CharW-1:0] char_code,
  input  wire ipv4dp_pkg::ipv4dp_state_t    cur,
  output ipv4dp_pkg::ipv4dp_state_t         nxt,
  output ipv4dp_pkg::ipv4dp_result_t        res
);

  logic                          is_dig;
  logic                          is_ws;
  logic                          is_hex_lo;
  logic                          is_hex_up;
  logic [3:0]                    dig_val;
  logic [ipv4dp_pkg::AddrW-1:0]  dig_ext;
  logic [ipv4dp_pkg::AddrW-1:0]  acc_dec;
  logic [ipv4dp_pkg::AddrW-1:0]  acc_oct;
  logic [ipv4dp_pkg::AddrW-1:0]  acc_hex;
  logic [1:0]                    base_eff;
  logic                          do_part;
  logic                          do_emit;
  logic                          emit_ok;
  logic [ipv4dp_pkg::AddrW-1:0]  emit_addr;
  logic                          too_big;
  logic [ipv4dp_pkg::AddrW-1:0]  merged;

  assign is_dig    = (char_code >= ipv4dp_pkg::CH_ZERO) && (char_code <= ipv4dp_pkg::CH_NINE);
  assign is_ws     = (char_code == ipv4dp_pkg::CH_SPACE) ||
                     ((char_code >= ipv4dp_pkg::CH_TAB) && (char_code <= ipv4dp_pkg::CH_CR));
  assign is_hex_lo = (char_code >= ipv4dp_pkg::CH_A_LO) && (char_code <= ipv4dp_pkg::CH_F_LO);
  assign is_hex_up = (char_code >= ipv4dp_pkg::CH_A_UP) && (char_code <= ipv4dp_pkg::CH_F_UP);

  always_comb begin
    if (is_hex_lo) begin
      dig_val = 4'(char_code - ipv4dp_pkg::CH_A_LO) + 4'd10;
    end else if (is_hex_up) begin
      dig_val = 4'(char_code - ipv4dp_pkg::CH_A_UP) + 4'd10;
    end else begin
      dig_val = 4'(char_code - ipv4dp_pkg::CH_ZERO);
    end
  end

  assign dig_ext = {{(ipv4dp_pkg::AddrW-4){1'b0}}, dig_val};
  assign acc_dec = (cur.part << 3) + (cur.part << 1) + dig_ext;
  assign acc_oct = (cur.part << 3) + dig_ext;
  assign acc_hex = (cur.part << 4) | dig_ext;

  // last part range check and merge of earlier parts
  always_comb begin
    too_big = 1'b0;
    merged  = cur.part;
    case (cur.seen)
      2'd1: begin
        too_big = cur.part > ipv4dp_pkg::LIMIT_24;
        merged  = cur.part | (cur.earlier[0] << 24);
      end
      2'd2: begin
        too_big = cur.part > ipv4dp_pkg::LIMIT_16;
        merged  = cur.part | (cur.earlier[0] << 24) | (cur.earlier[1] << 16);
      end
      2'd3: begin
        too_big = cur.part > ipv4dp_pkg::LIMIT_8;
        merged  = cur.part | (cur.earlier[0] << 24) | (cur.earlier[1] << 16) |
                  (cur.earlier[2] << 8);
      end
      default: begin
        too_big = 1'b0;
        merged  = cur.part;
      end
    endcase
  end

  always_comb begin
    nxt       = cur;
    base_eff  = cur.base;
    do_part   = 1'b0;
    do_emit   = 1'b0;
    emit_ok   = 1'b0;
    emit_addr = '0;

    unique case (cur.phase)
      ipv4dp_pkg::PH_START: begin
        if (!is_dig) begin
          do_emit = 1'b1;
        end else if (char_code == ipv4dp_pkg::CH_ZERO) begin
          nxt.part  = '0;
          nxt.phase = ipv4dp_pkg::PH_ZERO;
        end else begin
          nxt.base  = ipv4dp_pkg::BASE_DEC;
          nxt.part  = dig_ext;
          nxt.phase = ipv4dp_pkg::PH_DIGITS;
        end
      end
      ipv4dp_pkg::PH_ZERO: begin
        nxt.phase = ipv4dp_pkg::PH_DIGITS;
        if ((char_code == ipv4dp_pkg::CH_X_LO) || (char_code == ipv4dp_pkg::CH_X_UP)) begin
          nxt.base = ipv4dp_pkg::BASE_HEX;
        end else begin
          nxt.base = ipv4dp_pkg::BASE_OCT;
          base_eff = ipv4dp_pkg::BASE_OCT;
          do_part  = 1'b1;
        end
      end
      ipv4dp_pkg::PH_DIGITS: begin
        do_part = 1'b1;
      end
      ipv4dp_pkg::PH_SKIP: begin
        if (char_code == ipv4dp_pkg::CH_NUL) begin
          nxt.base  = ipv4dp_pkg::BASE_DEC;
          nxt.part  = '0;
          nxt.seen  = '0;
          nxt.phase = ipv4dp_pkg::PH_START;
        end
      end
      default: begin
        nxt.phase = ipv4dp_pkg::PH_START;
      end
    endcase

    if (do_part) begin
      if (is_dig) begin
        if (base_eff == ipv4dp_pkg::BASE_HEX) begin
          nxt.part = acc_hex;
        end else if (base_eff == ipv4dp_pkg::BASE_OCT) begin
          nxt.part = acc_oct;
        end else begin
          nxt.part = acc_dec;
        end
      end else if ((base_eff == ipv4dp_pkg::BASE_HEX) && (is_hex_lo || is_hex_up)) begin
        nxt.part = acc_hex;
      end else if (char_code == ipv4dp_pkg::CH_DOT) begin
        if (cur.seen == 2'd3) begin
          do_emit = 1'b1;
        end else begin
          case (cur.seen)
            2'd0:    nxt.earlier[0] = cur.part;
            2'd1:    nxt.earlier[1] = cur.part;
            default: nxt.earlier[2] = cur.part;
          endcase
          nxt.seen  = cur.seen + 2'd1;
          nxt.part  = '0;
          nxt.base  = ipv4dp_pkg::BASE_DEC;
          nxt.phase = ipv4dp_pkg::PH_START;
        end
      end else if ((char_code == ipv4dp_pkg::CH_NUL) || is_ws) begin
        do_emit   = 1'b1;
        emit_ok   = !too_big;
        emit_addr = too_big ? '0 : merged;
      end else begin
        do_emit = 1'b1;
      end
    end

    if (do_emit) begin
      nxt.base  = ipv4dp_pkg::BASE_DEC;
      nxt.part  = '0;
      nxt.seen  = '0;
      nxt.phase = (char_code == ipv4dp_pkg::CH_NUL) ? ipv4dp_pkg::PH_START
                                                    : ipv4dp_pkg::PH_SKIP;
    end

    res.emit    = do_emit;
    res.ok      = emit_ok;
    res.address = emit_addr;
  end

endmodule
`default_nettype wire

// File: hdl/ipv4_dotted_text_parser.sv
// Channel | Direction | Ports                               | Transfer when
// input   | in        | in_char_code                        | in_valid && in_ready
// result  | out       | out_address, out_valid_res          | out_valid && out_ready
//
// One character per cycle while the result register does not stall: a transfer lands in an
// input register, whose character then updates the parser state and, on a terminator or
// error, loads the result register. The rate is set by the result register, which holds
// while out_ready is low and stalls the input register behind it.
// rst_n (synchronous) clears the parser to the start of a new text and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_dotted_text_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output wire logic                          in_ready,
  input  wire logic [ipv4dp_pkg::CharW-1:0]  in_char_code,
  output wire logic                          out_valid,
  input  wire logic                          out_ready,
  output wire logic [ipv4dp_pkg::AddrW-1:0]  out_address,
  output wire logic                          out_valid_res
);

  logic [ipv4dp_pkg::CharW-1:0] char_r;
  logic                         char_vld_r;
  logic                         out_vld_r;
  logic [ipv4dp_pkg::AddrW-1:0] out_addr_r;
  logic                         out_ok_r;
  logic                         advance;

  ipv4dp_pkg::ipv4dp_state_t  st_r;
  ipv4dp_pkg::ipv4dp_state_t  st_nxt;
  ipv4dp_pkg::ipv4dp_result_t res;

  assign advance  = char_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !char_vld_r || advance;

  ipv4dp_step u_step (
    .char_code (char_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
    end else if (in_ready) begin
      char_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= ipv4dp_pkg::PH_START;
      st_r.base    <= ipv4dp_pkg::BASE_DEC;
      st_r.part    <= '0;
      st_r.seen    <= '0;
      st_r.earlier <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_addr_r <= res.address;
      out_ok_r   <= res.ok;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_address   = out_addr_r;
  assign out_valid_res = out_ok_r;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int CharW = ipv4dp_pkg::CharW;
  localparam int AddrW = ipv4dp_pkg::AddrW;

  class addr_scoreboard;
    logic [1:0]                 phase;
    logic [1:0]                 base;
    logic [1:0]                 seen;
    logic [AddrW-1:0]           part;
    logic [AddrW-1:0]           earlier [3];
    ipv4dp_pkg::ipv4dp_result_t pending [$];
    int errors;
    int n_chars;
    int n_valid;
    int n_invalid;

    function new();
      phase = ipv4dp_pkg::PH_START;
      base = ipv4dp_pkg::BASE_DEC;
      seen = '0;
      part = '0;
      foreach (earlier[i]) earlier[i] = '0;
      errors = 0;
      n_chars = 0;
      n_valid = 0;
      n_invalid = 0;
    endfunction

    function bit is_digit(logic [CharW-1:0] c);
      return c >= ipv4dp_pkg::CH_ZERO && c <= ipv4dp_pkg::CH_NINE;
    endfunction

    function bit is_space(logic [CharW-1:0] c);
      return c == ipv4dp_pkg::CH_SPACE ||
             (c >= ipv4dp_pkg::CH_TAB && c <= ipv4dp_pkg::CH_CR);
    endfunction

    function void push_result(logic [CharW-1:0] c, logic [AddrW-1:0] addr, logic ok);
      ipv4dp_pkg::ipv4dp_result_t r;
      r.emit = 1'b1;
      r.address = ok ? addr : '0;
      r.ok = ok;
      pending.push_back(r);
      base = ipv4dp_pkg::BASE_DEC;
      part = '0;
      seen = '0;
      phase = (c == ipv4dp_pkg::CH_NUL) ? ipv4dp_pkg::PH_START : ipv4dp_pkg::PH_SKIP;
    endfunction

    function void end_text(logic [CharW-1:0] c);
      logic [AddrW-1:0] v;
      v = part;
      case (seen)
        2'd1: begin
          if (v > ipv4dp_pkg::LIMIT_24) begin
            push_result(c, '0, 1'b0);
            return;
          end
          v |= earlier[0] << 24;
        end
        2'd2: begin
          if (v > ipv4dp_pkg::LIMIT_16) begin
            push_result(c, '0, 1'b0);
            return;
          end
          v |= (earlier[0] << 24) | (earlier[1] << 16);
        end
        2'd3: begin
          if (v > ipv4dp_pkg::LIMIT_8) begin
            push_result(c, '0, 1'b0);
            return;
          end
          v |= (earlier[0] << 24) | (earlier[1] << 16) | (earlier[2] << 8);
        end
        default: ;
      endcase
      push_result(c, v, 1'b1);
    endfunction

    function void step_part(logic [CharW-1:0] c);
      logic [AddrW-1:0] mul;
      if (is_digit(c)) begin
        mul = (base == ipv4dp_pkg::BASE_HEX) ? 16 : ((base == ipv4dp_pkg::BASE_OCT) ? 8 : 10);
        part = part * mul + AddrW'(c - ipv4dp_pkg::CH_ZERO);
      end else if (base == ipv4dp_pkg::BASE_HEX &&
                   c >= ipv4dp_pkg::CH_A_LO && c <= ipv4dp_pkg::CH_F_LO) begin
        part = (part << 4) | AddrW'(c - ipv4dp_pkg::CH_A_LO + 8'd10);
      end else if (base == ipv4dp_pkg::BASE_HEX &&
                   c >= ipv4dp_pkg::CH_A_UP && c <= ipv4dp_pkg::CH_F_UP) begin
        part = (part << 4) | AddrW'(c - ipv4dp_pkg::CH_A_UP + 8'd10);
      end else if (c == ipv4dp_pkg::CH_DOT) begin
        if (seen == 2'd3) begin
          push_result(c, '0, 1'b0);
        end else begin
          earlier[seen] = part;
          seen++;
          part = '0;
          base = ipv4dp_pkg::BASE_DEC;
          phase = ipv4dp_pkg::PH_START;
        end
      end else if (c == ipv4dp_pkg::CH_NUL || is_space(c)) begin
        end_text(c);
      end else begin
        push_result(c, '0, 1'b0);
      end
    endfunction

    // one accepted input transfer
    function void note_char(logic [CharW-1:0] c);
      n_chars++;
      case (phase)
        ipv4dp_pkg::PH_START: begin
          if (!is_digit(c)) begin
            push_result(c, '0, 1'b0);
          end else begin
            part = '0;
            if (c == ipv4dp_pkg::CH_ZERO) begin
              phase = ipv4dp_pkg::PH_ZERO;
            end else begin
              base = ipv4dp_pkg::BASE_DEC;
              part = AddrW'(c - ipv4dp_pkg::CH_ZERO);
              phase = ipv4dp_pkg::PH_DIGITS;
            end
          end
        end
        ipv4dp_pkg::PH_ZERO: begin
          phase = ipv4dp_pkg::PH_DIGITS;
          if (c == ipv4dp_pkg::CH_X_LO || c == ipv4dp_pkg::CH_X_UP) begin
            base = ipv4dp_pkg::BASE_HEX;
          end else begin
            base = ipv4dp_pkg::BASE_OCT;
            step_part(c);
          end
        end
        ipv4dp_pkg::PH_DIGITS: step_part(c);
        default: begin
          if (c == ipv4dp_pkg::CH_NUL) begin
            base = ipv4dp_pkg::BASE_DEC;
            part = '0;
            seen = '0;
            phase = ipv4dp_pkg::PH_START;
          end
        end
      endcase
    endfunction

    // one accepted output transfer
    function void check_result(logic [AddrW-1:0] addr, logic ok);
      ipv4dp_pkg::ipv4dp_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: address %h valid_res %b", addr, ok);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (ok) n_valid++;
      else n_invalid++;
      if (addr !== r.address) begin
        $error("address: expected %h, actual %h", r.address, addr);
        errors++;
      end
      if (ok !== r.ok) begin
        $error("valid_res: expected %b, actual %b", r.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [CharW-1:0] in_char_code = '0;
  logic             out_ready = 1'b0;
  wire              in_ready;
  wire              out_valid;
  wire [AddrW-1:0]  out_address;
  wire              out_valid_res;

  addr_scoreboard   sb;
  bit               gaps_on = 1'b1;
  bit               stalls_on = 1'b1;
  logic [CharW-1:0] text_buf [$];

  ipv4_dotted_text_parser u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_address  (out_address),
    .out_valid_res(out_valid_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic send_buf();
    while (text_buf.size() != 0) send_char(text_buf.pop_front());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s, input logic [CharW-1:0] term);
    add_str(s);
    text_buf.push_back(term);
    send_buf();
  endtask

  function string make_part(logic [AddrW-1:0] v);
    string s;
    int k;
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", v);
      1: begin
        s = {"0", $sformatf("%0o", v)};
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, s.len() - 1);
          s.putc(k, CharW'(ipv4dp_pkg::CH_NINE - $urandom_range(0, 1)));
        end
      end
      default: begin
        if ($urandom_range(0, 19) == 0) s = "";
        else s = $sformatf("%0h", v);
        if ($urandom_range(0, 1)) s = s.toupper();
        if ($urandom_range(0, 1)) s = {"0x", s};
        else s = {"0X", s};
      end
    endcase
    return s;
  endfunction

  function void build_address();
    int n;
    logic [AddrW-1:0] v;
    logic [AddrW-1:0] cap;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n - 1; i++) begin
      v = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 255) : $urandom;
      add_str(make_part(v));
      text_buf.push_back(ipv4dp_pkg::CH_DOT);
    end
    cap = (n == 1) ? '1 : (n == 2) ? ipv4dp_pkg::LIMIT_24 :
          (n == 3) ? ipv4dp_pkg::LIMIT_16 : ipv4dp_pkg::LIMIT_8;
    if (n > 1 && $urandom_range(0, 6) == 0) v = cap + $urandom_range(1, 3);
    else if ($urandom_range(0, 4) == 0) v = cap - $urandom_range(0, 2);
    else v = $urandom_range(0, cap);
    add_str(make_part(v));
  endfunction

  function void add_terminator();
    if ($urandom_range(0, 99) < 55) begin
      text_buf.push_back(ipv4dp_pkg::CH_NUL);
    end else begin
      if ($urandom_range(0, 2) == 0) text_buf.push_back(ipv4dp_pkg::CH_SPACE);
      else text_buf.push_back(CharW'($urandom_range(ipv4dp_pkg::CH_TAB, ipv4dp_pkg::CH_CR)));
      repeat ($urandom_range(0, 6)) text_buf.push_back(CharW'($urandom_range(1, 255)));
      text_buf.push_back(ipv4dp_pkg::CH_NUL);
    end
  endfunction

  initial begin
    int texts;
    int r;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_text("255.255.255.255", ipv4dp_pkg::CH_NUL);
    send_text("0x0.0XfF.0xAb.0", ipv4dp_pkg::CH_NUL);
    send_text("0x", ipv4dp_pkg::CH_NUL);
    send_text("017.089", ipv4dp_pkg::CH_NUL);
    send_text("4294967295", ipv4dp_pkg::CH_NUL);
    send_text("99999999999", ipv4dp_pkg::CH_NUL);
    send_text("1.16777216", ipv4dp_pkg::CH_NUL);
    send_text("1.2.65536", ipv4dp_pkg::CH_NUL);
    send_text("1.2.3.256", ipv4dp_pkg::CH_NUL);
    send_text("1.2.3.4.5", ipv4dp_pkg::CH_NUL);
    send_text("", ipv4dp_pkg::CH_NUL);
    send_text(".1", ipv4dp_pkg::CH_NUL);
    send_text("1.2.3.", ipv4dp_pkg::CH_NUL);
    send_text("0xg", ipv4dp_pkg::CH_NUL);
    send_text("256.0.0.1", ipv4dp_pkg::CH_SPACE);
    send_text("xyz", ipv4dp_pkg::CH_NUL);
    send_text("7", ipv4dp_pkg::CH_TAB);
    send_text("", ipv4dp_pkg::CH_NUL);
    send_text("0", ipv4dp_pkg::CH_CR);
    send_text("9", ipv4dp_pkg::CH_NUL);
    send_text("12", 8'hff);
    send_text("", ipv4dp_pkg::CH_NUL);
    send_text("", 8'h80);
    send_text("", ipv4dp_pkg::CH_NUL);

    texts = 0;
    while (sb.n_chars < 1300) begin
      if (texts % 40 == 0) begin
        gaps_on = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      if (texts == 30) drain();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        build_address();
        add_terminator();
      end else if (r < 90) begin
        build_address();
        case ($urandom_range(0, 2))
          0: text_buf.insert($urandom_range(0, text_buf.size()),
                             CharW'($urandom_range(1, 255)));
          1: text_buf[$urandom_range(0, text_buf.size() - 1)] = CharW'($urandom_range(1, 255));
          default: begin
            text_buf.push_back(ipv4dp_pkg::CH_DOT);
            repeat ($urandom_range(1, 3)) begin
              add_str(make_part($urandom_range(0, 255)));
              text_buf.push_back(ipv4dp_pkg::CH_DOT);
            end
            add_str(make_part($urandom_range(0, 255)));
          end
        endcase
        text_buf.push_back(ipv4dp_pkg::CH_NUL);
      end else begin
        repeat ($urandom_range(1, 10)) text_buf.push_back(CharW'($urandom_range(0, 255)));
        text_buf.push_back(ipv4dp_pkg::CH_NUL);
      end
      send_buf();
      texts++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters over directed and %0d random texts,",
             sb.n_chars, texts);
    $display("checked %0d valid and %0d invalid addresses.", sb.n_valid, sb.n_invalid);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_address, out_valid_res);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on) stall = pick_gap();
      end
    end
  end

endmodule
